### hw/rtl/ppbs_pkg.sv
// package for the proportional power budget split core
// field widths, reset constants, controller state type and command/status structs
// no dependencies
package ppbs_pkg;

  localparam int unsigned MAX_GPUS_DEF     = 8;
  localparam int unsigned BUDGET_W         = 16;
  localparam int unsigned UTIL_W           = 7;
  localparam int unsigned POWER_W          = 12;
  localparam int unsigned INDEX_W          = 3;
  localparam int unsigned PROD_W           = BUDGET_W + UTIL_W;
  localparam logic [POWER_W-1:0] IDLE_POWER_RESET = POWER_W'(30);

  typedef enum logic [2:0] {
    S_LOAD,
    S_IP_RD,
    S_IP_ACC,
    S_AL_RD,
    S_AL_MUL,
    S_AL_DIVST,
    S_AL_DIV,
    S_AL_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic ip_step;
    logic idx_clr;
    logic idx_inc;
    logic mul;
    logic div_start;
    logic out_load;
    logic set_clr;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic rd_idle;
    logic div_busy;
    logic out_full;
  } stat_t;

endpackage

### hw/rtl/ppbs_div.sv
// iterative restoring divider, one quotient bit per cycle
// no dependencies; widths come from the caller's parameters
module ppbs_div #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W+1:0] rem_sh;
  logic [DEN_W+1:0] rem_diff;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, q_r[NUM_W-1]};
    rem_diff = rem_sh - {2'b00, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      q_nxt    = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!rem_diff[DEN_W+1]) begin
        rem_nxt = rem_diff[DEN_W:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

### hw/rtl/ppbs_dp.sv
// datapath: device stores, set counters, budget, multiplier, divider, clamp, output register
// depends on ppbs_pkg and ppbs_div
module ppbs_dp #(
  parameter int unsigned MAX_GPUS = ppbs_pkg::MAX_GPUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppbs_pkg::cmd_t                cmd,
  output ppbs_pkg::stat_t               stat,
  input  logic                          cfg_we,
  input  logic [ppbs_pkg::POWER_W-1:0]  cfg_idle_power,
  input  logic [ppbs_pkg::BUDGET_W-1:0] in_power_budget,
  input  logic [ppbs_pkg::UTIL_W-1:0]   in_utilization,
  input  logic [ppbs_pkg::POWER_W-1:0]  in_min_power,
  input  logic [ppbs_pkg::POWER_W-1:0]  in_max_power,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ppbs_pkg::INDEX_W-1:0]  out_device_index,
  output logic [ppbs_pkg::POWER_W-1:0]  out_alloc_power,
  output logic                          out_last_result
);

  import ppbs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_GPUS + 1);
  localparam int unsigned IW = (MAX_GPUS > 1) ? $clog2(MAX_GPUS) : 1;
  localparam int unsigned TW = $clog2(MAX_GPUS * ((1 << UTIL_W) - 1) + 1);

  logic [UTIL_W-1:0]  util_mem [MAX_GPUS];
  logic [POWER_W-1:0] min_mem  [MAX_GPUS];
  logic [POWER_W-1:0] max_mem  [MAX_GPUS];

  logic [POWER_W-1:0]  idle_r;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       idx_r;
  logic [TW-1:0]       tot_r;
  logic [BUDGET_W-1:0] budget_r;
  logic [UTIL_W-1:0]   util_rd_r;
  logic [POWER_W-1:0]  min_rd_r;
  logic [POWER_W-1:0]  max_rd_r;
  logic [PROD_W-1:0]   prod_r;

  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_idx_r;
  logic [POWER_W-1:0]  out_pow_r;
  logic                out_last_r;

  logic                div_busy;
  logic [PROD_W-1:0]   quot;
  logic [PROD_W-1:0]   clamp_hi;
  logic [POWER_W-1:0]  share;
  logic [POWER_W-1:0]  alloc;
  logic                idx_last;
  logic [CW+INDEX_W-1:0] idx_ext;

  assign idx_last = (CW'(idx_r + 1'b1) == cnt_r);
  assign idx_ext  = {{INDEX_W{1'b0}}, idx_r};

  // idle power register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= IDLE_POWER_RESET;
    end else if (cfg_we) begin
      idle_r <= cfg_idle_power;
    end
  end

  // device stores
  always_ff @(posedge clk) begin
    if (cmd.load && (cnt_r < CW'(MAX_GPUS))) begin
      util_mem[cnt_r[IW-1:0]] <= in_utilization;
      min_mem[cnt_r[IW-1:0]]  <= in_min_power;
      max_mem[cnt_r[IW-1:0]]  <= in_max_power;
    end
    if (cmd.rd) begin
      util_rd_r <= util_mem[idx_r[IW-1:0]];
      min_rd_r  <= min_mem[idx_r[IW-1:0]];
      max_rd_r  <= max_mem[idx_r[IW-1:0]];
    end
  end

  // set counters and budget
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      tot_r    <= '0;
      budget_r <= '0;
      idx_r    <= '0;
    end else begin
      if (cmd.load) begin
        if (cnt_r == '0) begin
          budget_r <= in_power_budget;
        end
        if (cnt_r < CW'(MAX_GPUS)) begin
          cnt_r <= cnt_r + 1'b1;
          tot_r <= tot_r + TW'(in_utilization);
        end
      end else if (cmd.set_clr) begin
        cnt_r    <= '0;
        tot_r    <= '0;
        budget_r <= '0;
      end else if (cmd.ip_step && (util_rd_r == '0)) begin
        if (budget_r > BUDGET_W'(idle_r)) begin
          budget_r <= budget_r - BUDGET_W'(idle_r);
        end else begin
          budget_r <= '0;
        end
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // share = budget * util / total
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(budget_r) * PROD_W'(util_rd_r);
    end
  end

  ppbs_div #(
    .NUM_W (PROD_W),
    .DEN_W (TW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (tot_r),
    .busy  (div_busy),
    .quot  (quot)
  );

  // clamp to max, then min
  always_comb begin
    clamp_hi = quot;
    if (quot > PROD_W'(max_rd_r)) begin
      clamp_hi = PROD_W'(max_rd_r);
    end
    share = clamp_hi[POWER_W-1:0];
    if (clamp_hi < PROD_W'(min_rd_r)) begin
      share = min_rd_r;
    end
    alloc = (util_rd_r == '0) ? idle_r : share;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_idx_r  <= idx_ext[INDEX_W-1:0];
      out_pow_r  <= alloc;
      out_last_r <= idx_last;
    end
  end

  assign stat.idx_last = idx_last;
  assign stat.rd_idle  = (util_rd_r == '0);
  assign stat.div_busy = div_busy;
  assign stat.out_full = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_device_index = out_idx_r;
  assign out_alloc_power  = out_pow_r;
  assign out_last_result  = out_last_r;

endmodule

### hw/rtl/ppbs_ctrl.sv
// controller state machine: load, idle reserve pass, per-device allocation
// depends on ppbs_pkg
module ppbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last_device,
  output logic            in_ready,
  input  ppbs_pkg::stat_t stat,
  output ppbs_pkg::cmd_t  cmd
);

  import ppbs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_device) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_IP_RD;
          end
        end
      end
      S_IP_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_IP_ACC;
      end
      S_IP_ACC: begin
        cmd.ip_step = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_AL_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_IP_RD;
        end
      end
      S_AL_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_AL_MUL;
      end
      S_AL_MUL: begin
        if (stat.rd_idle) begin
          state_nxt = S_AL_OUT;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_AL_DIVST;
        end
      end
      S_AL_DIVST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_AL_DIV;
      end
      S_AL_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_AL_OUT;
        end
      end
      S_AL_OUT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          if (stat.idx_last) begin
            cmd.set_clr = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_AL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

### hw/rtl/proportional_power_budget_split_core.sv
// Splits a power budget among up to MAX_GPUS devices. Non-last input transactions are taken
// back to back. On the last transaction of a set the block walks the stored devices twice: a
// reserve pass takes idle_power off the budget for each idle device, then an allocation pass
// emits one result per device in load order. An idle device is read and output directly; a
// busy one is also multiplied and divided by the shared restoring divider, which forms
// budget*util/total; a stalled output channel adds its wait. Input is held off during both
// passes, and the next set may load while the final result still waits in the output register.
// depends on ppbs_pkg, ppbs_ctrl, ppbs_dp
module proportional_power_budget_split_core #(
  parameter int unsigned MAX_GPUS = ppbs_pkg::MAX_GPUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ppbs_pkg::POWER_W-1:0]  cfg_idle_power,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ppbs_pkg::BUDGET_W-1:0] in_power_budget,
  input  logic [ppbs_pkg::UTIL_W-1:0]   in_utilization,
  input  logic [ppbs_pkg::POWER_W-1:0]  in_min_power,
  input  logic [ppbs_pkg::POWER_W-1:0]  in_max_power,
  input  logic                          in_last_device,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ppbs_pkg::INDEX_W-1:0]  out_device_index,
  output logic [ppbs_pkg::POWER_W-1:0]  out_alloc_power,
  output logic                          out_last_result
);

  import ppbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ppbs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_device (in_last_device),
    .in_ready       (in_ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  ppbs_dp #(
    .MAX_GPUS (MAX_GPUS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_idle_power   (cfg_idle_power),
    .in_power_budget  (in_power_budget),
    .in_utilization   (in_utilization),
    .in_min_power     (in_min_power),
    .in_max_power     (in_max_power),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_device_index (out_device_index),
    .out_alloc_power  (out_alloc_power),
    .out_last_result  (out_last_result)
  );

endmodule
